FILE: rtl/mtfp_pkg.sv
// Shared types and constants of the Modbus TCP FC3 response parser.
package mtfp_pkg;

  localparam int unsigned BUFFER_BYTES = 512;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = 16;
  localparam int unsigned QTY_W      = 7;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [QTY_W-1:0]  qty_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Byte positions inside the reply
  localparam pos_t POS_LEN_HI = pos_t'(4);
  localparam pos_t POS_LEN_LO = pos_t'(5);
  localparam pos_t POS_PDU    = pos_t'(6);
  localparam pos_t POS_FUNC   = pos_t'(7);
  localparam pos_t POS_COUNT  = pos_t'(8);
  localparam pos_t POS_DATA   = pos_t'(9);

  localparam byte_t FC_READ_HOLDING = 8'h03;
  localparam int unsigned EXC_BIT   = 7;

  localparam word_t LEN_MIN = word_t'(3);
  localparam word_t LEN_MAX = word_t'(BUFFER_BYTES - 6);

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_EXC   = 3'd1,
    ST_LEN   = 3'd2,
    ST_FUNC  = 3'd3,
    ST_COUNT = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BASE     = 4'd0,
    REG_QUANTITY = 4'd1
  } reg_idx_e;

  localparam word_t BASE_RESET = word_t'(4100);
  localparam qty_t  QTY_RESET  = qty_t'(113);

  typedef struct packed {
    word_t register_base;
    qty_t  register_quantity;
  } cfg_t;

  typedef struct packed {
    logic    word_valid;
    word_t   reg_address;
    word_t   reg_value;
    logic    frame_end;
    status_e frame_status;
  } res_t;

endpackage

FILE: rtl/mtfp_if.sv
// Handshake channels of the parser: received bytes, results, register writes.
interface mtfp_rx_if;
  logic                        valid;
  logic                        ready;
  logic [mtfp_pkg::BYTE_W-1:0] rx_byte;
  logic                        frame_start;
  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink   (input valid, rx_byte, frame_start, output ready);
endinterface

interface mtfp_res_if;
  logic                        valid;
  logic                        ready;
  logic                        word_valid;
  logic [mtfp_pkg::WORD_W-1:0] reg_address;
  logic [mtfp_pkg::WORD_W-1:0] reg_value;
  logic                        frame_end;
  logic [2:0]                  frame_status;
  modport source (output valid, word_valid, reg_address, reg_value, frame_end, frame_status,
                  input ready);
  modport sink   (input valid, word_valid, reg_address, reg_value, frame_end, frame_status,
                  output ready);
endinterface

interface mtfp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mtfp_pkg::CFG_IDX_W-1:0]  index;
  logic [mtfp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/mtfp_cfg_regs.sv
// Configuration registers: register base address and expected register count.
module mtfp_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  mtfp_cfg_if.sink          cfg_i,
  output mtfp_pkg::cfg_t    cfg_o
);

  mtfp_pkg::word_t base_q;
  mtfp_pkg::qty_t  qty_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= mtfp_pkg::BASE_RESET;
      qty_q  <= mtfp_pkg::QTY_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mtfp_pkg::REG_BASE:     base_q <= cfg_i.data[mtfp_pkg::WORD_W-1:0];
        mtfp_pkg::REG_QUANTITY: qty_q  <= cfg_i.data[mtfp_pkg::QTY_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.register_base     = base_q;
  assign cfg_o.register_quantity = qty_q;

endmodule

FILE: rtl/mtfp_parse.sv
// Frame state and per-byte decode of the reply header and register data.
module mtfp_parse (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mtfp_pkg::byte_t    rx_byte_i,
  input  logic               frame_start_i,
  input  mtfp_pkg::cfg_t     cfg_i,
  output logic               res_valid_o,
  output mtfp_pkg::res_t     res_o
);

  mtfp_pkg::pos_t  pos_q, pos_d;
  mtfp_pkg::word_t len_q, len_d;
  mtfp_pkg::byte_t func_q, func_d;
  mtfp_pkg::byte_t cnt_q, cnt_d;
  mtfp_pkg::byte_t hold_q, hold_d;
  mtfp_pkg::qty_t  widx_q, widx_d;
  logic            closed_q, closed_d;

  logic            active;
  mtfp_pkg::pos_t  pos;
  mtfp_pkg::word_t len_b;
  mtfp_pkg::byte_t func_b, cnt_b, hold_b;
  mtfp_pkg::qty_t  widx_b;
  mtfp_pkg::byte_t qty2;
  mtfp_pkg::word_t len_lo;
  mtfp_pkg::byte_t func_e, cnt_e;
  mtfp_pkg::pos_t  doff;
  logic            hdr_good, in_data, word, fin_len, fin_pos, fin;
  mtfp_pkg::status_e st_fin;

  // A start byte sees the frame state as freshly cleared
  assign active = frame_start_i || !closed_q;
  assign pos    = frame_start_i ? '0 : pos_q;
  assign len_b  = frame_start_i ? '0 : len_q;
  assign func_b = frame_start_i ? '0 : func_q;
  assign cnt_b  = frame_start_i ? '0 : cnt_q;
  assign hold_b = frame_start_i ? '0 : hold_q;
  assign widx_b = frame_start_i ? '0 : widx_q;

  assign qty2   = {cfg_i.register_quantity, 1'b0};
  assign len_lo = {len_b[15:8], rx_byte_i};
  assign func_e = (pos == mtfp_pkg::POS_FUNC)  ? rx_byte_i : func_b;
  assign cnt_e  = (pos == mtfp_pkg::POS_COUNT) ? rx_byte_i : cnt_b;

  assign hdr_good = (func_b == mtfp_pkg::FC_READ_HOLDING) && (cnt_b == qty2) &&
                    ((mtfp_pkg::word_t'(cnt_b) + 16'd3) <= len_b);
  assign doff     = pos - mtfp_pkg::POS_DATA;
  assign in_data  = (pos >= mtfp_pkg::POS_DATA) && hdr_good &&
                    (doff < mtfp_pkg::pos_t'(cnt_b)) &&
                    (widx_b < cfg_i.register_quantity);
  assign word     = in_data && doff[0];

  assign fin_len = (pos == mtfp_pkg::POS_LEN_LO) &&
                   ((len_lo < mtfp_pkg::LEN_MIN) || (len_lo > mtfp_pkg::LEN_MAX));
  assign fin_pos = !fin_len && (pos >= mtfp_pkg::POS_PDU) &&
                   ({7'd0, pos} == ({1'b0, len_b} + 17'd5));
  assign fin     = fin_len || fin_pos;

  always_comb begin
    if (func_e[mtfp_pkg::EXC_BIT]) begin
      st_fin = mtfp_pkg::ST_EXC;
    end else if (func_e != mtfp_pkg::FC_READ_HOLDING) begin
      st_fin = mtfp_pkg::ST_FUNC;
    end else if (cnt_e != qty2) begin
      st_fin = mtfp_pkg::ST_COUNT;
    end else if ((mtfp_pkg::word_t'(cnt_e) + 16'd3) > len_b) begin
      st_fin = mtfp_pkg::ST_LEN;
    end else begin
      st_fin = mtfp_pkg::ST_OK;
    end
  end

  always_comb begin
    pos_d    = fin ? pos : pos + 10'd1;
    closed_d = fin;
    len_d    = len_b;
    func_d   = func_b;
    cnt_d    = cnt_b;
    hold_d   = hold_b;
    widx_d   = word ? widx_b + 7'd1 : widx_b;
    if (pos == mtfp_pkg::POS_LEN_HI) begin
      len_d = {rx_byte_i, 8'h00};
    end
    if (pos == mtfp_pkg::POS_LEN_LO) begin
      len_d = len_lo;
    end
    if (pos == mtfp_pkg::POS_FUNC) begin
      func_d = rx_byte_i;
    end
    if (pos == mtfp_pkg::POS_COUNT) begin
      cnt_d = rx_byte_i;
    end
    if (in_data && !doff[0]) begin
      hold_d = rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      len_q    <= '0;
      func_q   <= '0;
      cnt_q    <= '0;
      hold_q   <= '0;
      widx_q   <= '0;
      closed_q <= 1'b1;
    end else if (step_i && active) begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      func_q   <= func_d;
      cnt_q    <= cnt_d;
      hold_q   <= hold_d;
      widx_q   <= widx_d;
      closed_q <= closed_d;
    end
  end

  assign res_valid_o        = active && (word || fin);
  assign res_o.word_valid   = word;
  assign res_o.reg_address  = word ? cfg_i.register_base + mtfp_pkg::word_t'(widx_b) : '0;
  assign res_o.reg_value    = word ? {hold_b, rx_byte_i} : '0;
  assign res_o.frame_end    = fin;
  assign res_o.frame_status = fin ? (fin_len ? mtfp_pkg::ST_LEN : st_fin) : mtfp_pkg::ST_OK;

endmodule

FILE: rtl/modbus_tcp_fc3_response_parser_unit.sv
// Modbus TCP read-holding-registers reply parser, top level.
//
// rx_i carries the reply one byte per request, frame_start marking the first
// byte of a reply. res_o gives one request per register word (address is
// base plus index, value big-endian) and one at the frame end with its final
// status; a word on the last byte and the frame end share one request.
// Bytes that cause neither give no request. cfg_i writes register_base
// (index 0) and register_quantity (index 1); write only while idle.
// A byte accepted into the input register is decoded from there and
// written into the output register once res_o can advance. One byte per
// cycle is sustained while res_o takes its results; the decode is a few
// compares between the input register and the output register. When res_o
// stalls, the input register still holds one byte and rx_i drops ready
// once both are full. Reset empties both registers, closes the frame (bytes
// before a start are dropped) and loads base 4100 and quantity 113.
module modbus_tcp_fc3_response_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  mtfp_cfg_if.sink    cfg_i,
  mtfp_rx_if.sink     rx_i,
  mtfp_res_if.source  res_o
);

  mtfp_pkg::cfg_t  cfg;
  logic            in_valid_q;
  mtfp_pkg::byte_t in_byte_q;
  logic            in_start_q;
  logic            advance;
  logic            step;
  logic            dec_valid;
  mtfp_pkg::res_t  dec_res;
  logic            out_valid_q;
  mtfp_pkg::res_t  out_q;

  mtfp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign advance    = !out_valid_q || res_o.ready;
  assign step       = in_valid_q && advance;
  assign rx_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q  <= rx_i.rx_byte;
      in_start_q <= rx_i.frame_start;
    end
  end

  mtfp_parse u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .rx_byte_i     (in_byte_q),
    .frame_start_i (in_start_q),
    .cfg_i         (cfg),
    .res_valid_o   (dec_valid),
    .res_o         (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && dec_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= dec_res;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.word_valid   = out_q.word_valid;
  assign res_o.reg_address  = out_q.reg_address;
  assign res_o.reg_value    = out_q.reg_value;
  assign res_o.frame_end    = out_q.frame_end;
  assign res_o.frame_status = out_q.frame_status;

`ifndef ASSERT_OFF
  a_res_has_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.word_valid || out_q.frame_end))
    else $error("result carries neither word nor frame end");

  a_status_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.frame_end) |-> (out_q.frame_status == mtfp_pkg::ST_OK))
    else $error("status reported without frame end");

  a_no_word_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.word_valid) |-> (out_q.reg_address == '0 && out_q.reg_value == '0))
    else $error("word fields set without a word");
`endif

endmodule

FILE: sim/mtfp_reply_checker.sv
`timescale 1ns / 1ps
// Parser checker: predicts register words and frame ends from accepted bytes and compares.
module mtfp_reply_checker
  import mtfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mtfp_cfg_if  cfg_i,
  mtfp_rx_if   rx_i,
  mtfp_res_if  res_i,
  output int   pending_o,
  output int   fails_o
);

  word_t base_q;
  qty_t  qty_q;

  pos_t  pos_q;
  word_t len_q;
  byte_t func_q;
  byte_t count_q;
  byte_t hold_q;
  qty_t  widx_q;
  logic  closed_q;

  res_t  expected_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
    fails_o = fails_o + 1;
  endtask

  function automatic logic header_valid();
    return func_q == FC_READ_HOLDING && count_q == byte_t'({qty_q, 1'b0}) &&
           (9 + int'(count_q)) <= (6 + int'(len_q));
  endfunction

  function automatic status_e end_status();
    if (func_q[EXC_BIT]) return ST_EXC;
    if (func_q != FC_READ_HOLDING) return ST_FUNC;
    if (count_q != byte_t'({qty_q, 1'b0})) return ST_COUNT;
    if ((6 + int'(len_q)) < (9 + int'(count_q))) return ST_LEN;
    return ST_OK;
  endfunction

  task automatic parse_byte(input byte_t b, input logic s);
    int unsigned d;
    res_t r;
    logic fin;
    r = '0;
    fin = 1'b0;
    if (s) begin
      pos_q = '0;
      len_q = '0;
      func_q = '0;
      count_q = '0;
      hold_q = '0;
      widx_q = '0;
      closed_q = 1'b0;
    end else if (closed_q) begin
      return;
    end
    case (pos_q)
      POS_LEN_HI: len_q = {b, 8'h00};
      POS_LEN_LO: begin
        len_q = {len_q[15:8], b};
        if (len_q < LEN_MIN || len_q > LEN_MAX) begin
          fin = 1'b1;
          r.frame_status = ST_LEN;
        end
      end
      POS_FUNC:  func_q = b;
      POS_COUNT: count_q = b;
      default: begin
        if (pos_q >= POS_DATA) begin
          d = int'(pos_q) - int'(POS_DATA);
          if (header_valid() && d < count_q && widx_q < qty_q) begin
            if (d % 2 == 0) begin
              hold_q = b;
            end else begin
              r.word_valid = 1'b1;
              r.reg_address = base_q + word_t'(widx_q);
              r.reg_value = {hold_q, b};
              widx_q = widx_q + 1'b1;
            end
          end
        end
      end
    endcase
    if (!fin && pos_q >= POS_PDU && int'(pos_q) == int'(len_q) + 5) begin
      fin = 1'b1;
      r.frame_status = end_status();
    end
    if (fin) begin
      r.frame_end = 1'b1;
      closed_q = 1'b1;
    end else begin
      pos_q = pos_q + 1'b1;
    end
    if (r.word_valid || fin) expected_q.push_back(r);
  endtask

  task automatic check_result();
    res_t want;
    if (expected_q.size() == 0) begin
      report("unexpected request", res_i.reg_address, '0);
      return;
    end
    want = expected_q.pop_front();
    if (res_i.word_valid !== want.word_valid)
      report("word_valid", res_i.word_valid, want.word_valid);
    if (res_i.reg_address !== want.reg_address)
      report("reg_address", res_i.reg_address, want.reg_address);
    if (res_i.reg_value !== want.reg_value)
      report("reg_value", res_i.reg_value, want.reg_value);
    if (res_i.frame_end !== want.frame_end)
      report("frame_end", res_i.frame_end, want.frame_end);
    if (res_i.frame_status !== 3'(want.frame_status))
      report("frame_status", res_i.frame_status, want.frame_status);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q = BASE_RESET;
      qty_q = QTY_RESET;
      pos_q = '0;
      len_q = '0;
      func_q = '0;
      count_q = '0;
      hold_q = '0;
      widx_q = '0;
      closed_q = 1'b1;
      expected_q.delete();
      fails_o = 0;
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) check_result();
      if (cfg_i.valid && cfg_i.ready) begin
        case (reg_idx_e'(cfg_i.index))
          REG_BASE:     base_q = cfg_i.data;
          REG_QUANTITY: qty_q = cfg_i.data[QTY_W-1:0];
          default: ;
        endcase
      end
      if (rx_i.valid && rx_i.ready) parse_byte(rx_i.rx_byte, rx_i.frame_start);
      pending_o <= expected_q.size();
    end
  end

endmodule

FILE: sim/modbus_tcp_fc3_response_parser_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives reply byte streams and register writes into the parser.
module modbus_tcp_fc3_response_parser_unit_tb;
  import mtfp_pkg::*;

  typedef enum int {
    RP_GOOD, RP_CUT, RP_EXC, RP_FUNC, RP_COUNT, RP_SHORT, RP_BADLEN, RP_NOISE
  } reply_kind_e;

  localparam byte_t EXC_FLAG = byte_t'(1) << EXC_BIT;

  logic  clk_i;
  logic  rst_ni;
  int    pending;
  int    fails;
  int    sent;
  int    burst_left;
  bit    hold_req;
  byte_t reply_q[$];

  mtfp_cfg_if cfg_ch ();
  mtfp_rx_if  rx_ch ();
  mtfp_res_if res_ch ();

  modbus_tcp_fc3_response_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  mtfp_reply_checker reply_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_ch),
    .rx_i      (rx_ch),
    .res_i     (res_ch),
    .pending_o (pending),
    .fails_o   (fails)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  task automatic send_byte(input byte_t b, input logic s);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    rx_ch.frame_start <= s;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_reply(input bit with_start);
    int i;
    for (i = 0; i < reply_q.size(); i++) begin
      send_byte(reply_q[i], with_start && i == 0);
    end
    if (with_start) sent += reply_q.size();
  endtask

  task automatic drain();
    rx_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_config(input word_t base, input int qty);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_BASE;
    cfg_ch.data <= base;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.index <= REG_QUANTITY;
    cfg_ch.data <= word_t'(qty);
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic reply_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return RP_GOOD;
    if (r < 55) return RP_CUT;
    if (r < 63) return RP_EXC;
    if (r < 71) return RP_FUNC;
    if (r < 79) return RP_COUNT;
    if (r < 87) return RP_SHORT;
    if (r < 95) return RP_BADLEN;
    return RP_NOISE;
  endfunction

  task automatic make_reply(input reply_kind_e kind, input int qty, input bit longest);
    int    cnt;
    int    len;
    int    total;
    int    keep;
    int    i;
    byte_t func;
    byte_t count;
    cnt = 2 * qty;
    func = FC_READ_HOLDING;
    count = byte_t'(cnt);
    len = $urandom_range(3, 12);
    reply_q.delete();
    if (kind == RP_NOISE) begin
      repeat ($urandom_range(1, 4)) reply_q.push_back(byte_t'($urandom));
      return;
    end
    case (kind)
      RP_GOOD, RP_CUT: begin
        len = 3 + cnt + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 0);
        if (longest) len = LEN_MAX;
      end
      RP_EXC: begin
        func = byte_t'($urandom) | EXC_FLAG;
        count = byte_t'($urandom);
      end
      RP_FUNC: begin
        do func = byte_t'($urandom_range(0, 127)); while (func == FC_READ_HOLDING);
        count = byte_t'($urandom);
      end
      RP_COUNT: begin
        do count = byte_t'($urandom); while (count == byte_t'(cnt));
      end
      RP_SHORT: len = $urandom_range(3, 2 + cnt);
      RP_BADLEN: len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2)
                                                   : $urandom_range(LEN_MAX + 1, 16'hFFFF);
      default: ;
    endcase
    total = (kind == RP_BADLEN) ? 6 : len + 6;
    for (i = 0; i < total; i++) reply_q.push_back(byte_t'($urandom));
    reply_q[4] = len[15:8];
    reply_q[5] = len[7:0];
    if (kind != RP_BADLEN) begin
      reply_q[7] = func;
      reply_q[8] = count;
    end
    if (kind == RP_CUT) begin
      keep = $urandom_range(1, total - 1);
      repeat (total - keep) void'(reply_q.pop_back());
    end else if ($urandom_range(0, 3) == 0) begin
      // trailing bytes after the frame end are dropped by the block
      repeat ($urandom_range(1, 3)) reply_q.push_back(byte_t'($urandom));
    end
  endtask

  initial begin
    int          mode_left;
    int          stall_pct;
    int          hold_left;
    bit          held;
    res_ch.ready <= 1'b0;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(8, 80);
          case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 50;
            default: stall_pct = 80;
          endcase
        end
        mode_left--;
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  initial begin
    int          budget;
    int          phase;
    int          qty;
    bit          first;
    word_t       base;
    reply_kind_e kind;
    rst_ni <= 1'b0;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= '0;
    rx_ch.frame_start <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_BASE;
    cfg_ch.data <= '0;
    sent = 0;
    burst_left = 0;
    hold_req = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle byte, exception reply, length too short for the count, bad MBAP length
    send_byte(8'hA5, 1'b0);
    reply_q = {8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h03, 8'hFF,
               FC_READ_HOLDING | EXC_FLAG, 8'h02};
    send_reply(1'b1);
    reply_q = {8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h03, 8'h11,
               FC_READ_HOLDING, byte_t'(2 * QTY_RESET)};
    send_reply(1'b1);
    reply_q = {8'h00, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00};
    send_reply(1'b1);
    drain();

    phase = 0;
    qty = QTY_RESET;
    while (sent < 1250) begin
      if (phase > 0) begin
        case (phase)
          1: begin
            base = 16'hFFFF;
            qty = 125;
          end
          2: begin
            base = 16'h0000;
            qty = 1;
          end
          3: begin
            base = 16'hFFFE;
            qty = 4;
          end
          default: begin
            base = word_t'($urandom);
            qty = $urandom_range(1, 8);
          end
        endcase
        drain();
        write_config(base, qty);
        if (phase == 1) hold_req = 1'b1;
      end
      budget = sent + ((phase == 1) ? 700 : (qty > 16) ? 500 : 160);
      first = 1'b1;
      while (sent < budget) begin
        kind = (phase == 1 && first) ? RP_GOOD : pick_kind();
        make_reply(kind, qty, phase == 1 && first);
        send_reply(kind != RP_NOISE);
        if (phase == 2 && first) drain();
        first = 1'b0;
      end
      phase++;
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("modbus_tcp_fc3_response_parser_unit verification clean");
    end else begin
      $display("modbus_tcp_fc3_response_parser_unit verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("modbus_tcp_fc3_response_parser_unit verification failed");
    $finish;
  end

endmodule
